// File: hdl/stepper_zone_positioner_assert.svh
// assertion macros for the stepper zone positioner
// needs clk_i and rst_ni in the scope of every use
`ifndef STEPPER_ZONE_POSITIONER_ASSERT_SVH
`define STEPPER_ZONE_POSITIONER_ASSERT_SVH

// checked only outside reset
`define SZP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SZP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/szp_pkg.sv
// shared types and constants of the stepper zone positioner
// no dependencies
`default_nettype none

package szp_pkg;

  localparam int unsigned ZONES      = 6;
  localparam int unsigned SPZ_MAX    = 16;
  localparam int unsigned DIST_MUL   = 1047;
  localparam int unsigned DIST_DIV   = 100;
  localparam int unsigned OK_LIMIT   = 50;
  // count * 1047 / 100 as count * ceil(10.47 * 2^23) >> 23, exact for 16-bit counts
  localparam int unsigned DIST_RECIP = 87828726;
  localparam int unsigned DIST_SHIFT = 23;
  localparam int unsigned PROD_W     = 43;
  localparam int unsigned DIST_W     = 20;
  localparam int unsigned STEPS_W    = 6;

  localparam logic [1:0] CFG_ZONE_STEPS = 2'd0;
  localparam logic [1:0] CFG_TRIM_STEPS = 2'd1;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_ADJUST = 2'd1,
    OP_SENSE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SENSE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  target_zone;
    logic [15:0] sonar_count;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       stepped;
    logic       near_ok;
    logic       last;
  } out_beat_t;

  function automatic logic [3:0] coil_row(input logic [2:0] ph);
    logic [3:0] row;
    case (ph)
      3'd0: row = 4'd5;
      3'd1: row = 4'd1;
      3'd2: row = 4'd9;
      3'd3: row = 4'd8;
      3'd4: row = 4'd10;
      3'd5: row = 4'd2;
      3'd6: row = 4'd6;
      3'd7: row = 4'd4;
      default: row = 4'd0;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

// File: hdl/stepper_zone_positioner.sv
// stepper zone positioner: half-step sequencer over a ring of six zones
// depends on szp_pkg and stepper_zone_positioner_assert.svh
// move/adjust: n step beats (n up to 48), each registered from the step state, which output stalls hold
// sense: reciprocal multiply at accept, its beat registered from the sense state
// no-step, bad-target and unused ops give no beat; input stalls until back in idle
// asynchronous active-low reset: zone 1, phase 0, forward, distance 0, flag 0, 16 and 3 steps
`default_nettype none

module stepper_zone_positioner (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  szp_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output szp_pkg::out_beat_t   out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [4:0]           cfg_data_i
);

  szp_pkg::state_e state_q, state_d;
  logic [4:0] spz_q, spz_d;
  logic [3:0] adj_q, adj_d;
  logic [2:0] zone_q, zone_d;
  logic [2:0] phase_q, phase_d;
  logic       fwd_q, fwd_d;
  logic [szp_pkg::DIST_W-1:0]  last_dist_q, last_dist_d;
  logic       ok_q, ok_d;
  logic [szp_pkg::STEPS_W-1:0] left_q, left_d;
  logic [szp_pkg::DIST_W-1:0]  mm_q, mm_d;
  logic       out_valid_q, out_valid_d;
  szp_pkg::out_beat_t out_q, out_d;

  logic       in_acc;
  logic       out_free;
  logic [3:0] ring_sum;
  logic [2:0] dz;
  logic [1:0] dmove;
  logic       move_fwd;
  logic [4:0] spz_eff;
  logic       target_ok;
  logic [szp_pkg::PROD_W-1:0] prod;
  logic [szp_pkg::DIST_W:0]   diff;
  logic       closer;
  logic       sense_ok;
  logic [2:0] phase_next;
  logic       op_unused;
  logic       sense_beat_ok;

  assign in_stall_o  = (state_q != szp_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == szp_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ring distance and direction of a move
  assign ring_sum  = {1'b0, in_data_i.target_zone} + 4'(szp_pkg::ZONES) - {1'b0, zone_q};
  assign dz        = (ring_sum >= 4'(szp_pkg::ZONES)) ? 3'(ring_sum - 4'(szp_pkg::ZONES))
                                                      : ring_sum[2:0];
  assign move_fwd  = (dz <= 3'd3);
  assign dmove     = move_fwd ? dz[1:0] : 2'(3'(szp_pkg::ZONES) - dz);
  assign spz_eff   = (spz_q > 5'(szp_pkg::SPZ_MAX)) ? 5'(szp_pkg::SPZ_MAX) : spz_q;
  assign target_ok = (in_data_i.target_zone != 3'd0) && (in_data_i.target_zone != 3'd7);

  // distance in mm by reciprocal multiplication
  assign prod = szp_pkg::PROD_W'(in_data_i.sonar_count) * szp_pkg::PROD_W'(szp_pkg::DIST_RECIP);

  assign diff     = {1'b0, last_dist_q} - {1'b0, mm_q};
  assign closer   = !diff[szp_pkg::DIST_W] && (diff != '0);
  assign sense_ok = !diff[szp_pkg::DIST_W] && (diff < (szp_pkg::DIST_W+1)'(szp_pkg::OK_LIMIT));

  assign phase_next = fwd_q ? 3'(phase_q + 3'd1) : 3'(phase_q - 3'd1);

  always_comb begin
    state_d     = state_q;
    spz_d       = spz_q;
    adj_d       = adj_q;
    zone_d      = zone_q;
    phase_d     = phase_q;
    fwd_d       = fwd_q;
    last_dist_d = last_dist_q;
    ok_d        = ok_q;
    left_d      = left_q;
    mm_d        = mm_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        szp_pkg::CFG_ZONE_STEPS: spz_d = cfg_data_i;
        szp_pkg::CFG_TRIM_STEPS: adj_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      szp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.op)
            szp_pkg::OP_MOVE: begin
              if (target_ok) begin
                fwd_d  = move_fwd;
                zone_d = in_data_i.target_zone;
                left_d = {4'b0000, dmove} * {1'b0, spz_eff};
                if (left_d != '0) begin
                  state_d = szp_pkg::ST_STEP;
                end
              end
            end
            szp_pkg::OP_ADJUST: begin
              left_d = {2'b00, adj_q};
              if (adj_q != 4'd0) begin
                state_d = szp_pkg::ST_STEP;
              end
            end
            szp_pkg::OP_SENSE: begin
              mm_d    = prod[szp_pkg::DIST_SHIFT +: szp_pkg::DIST_W];
              state_d = szp_pkg::ST_SENSE;
            end
            default: ;
          endcase
        end
      end
      szp_pkg::ST_STEP: begin
        if (out_free) begin
          phase_d         = phase_next;
          out_valid_d     = 1'b1;
          out_d.coils     = szp_pkg::coil_row(phase_next);
          out_d.stepped   = 1'b1;
          out_d.near_ok   = ok_q;
          out_d.last      = (left_q == szp_pkg::STEPS_W'(1));
          left_d          = left_q - szp_pkg::STEPS_W'(1);
          if (left_q == szp_pkg::STEPS_W'(1)) begin
            state_d = szp_pkg::ST_IDLE;
          end
        end
      end
      szp_pkg::ST_SENSE: begin
        if (out_free) begin
          last_dist_d     = mm_q;
          fwd_d           = fwd_q ^ closer;
          ok_d            = sense_ok;
          out_valid_d     = 1'b1;
          out_d.coils     = 4'd0;
          out_d.stepped   = 1'b0;
          out_d.near_ok   = sense_ok;
          out_d.last      = 1'b1;
          state_d         = szp_pkg::ST_IDLE;
        end
      end
      default: state_d = szp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= szp_pkg::ST_IDLE;
      spz_q       <= 5'(szp_pkg::SPZ_MAX);
      adj_q       <= 4'd3;
      zone_q      <= 3'd1;
      phase_q     <= 3'd0;
      fwd_q       <= 1'b1;
      last_dist_q <= '0;
      ok_q        <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      spz_q       <= spz_d;
      adj_q       <= adj_d;
      zone_q      <= zone_d;
      phase_q     <= phase_d;
      fwd_q       <= fwd_d;
      last_dist_q <= last_dist_d;
      ok_q        <= ok_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q  <= mm_d;
    out_q <= out_d;
  end

  assign op_unused     = (in_data_i.op != szp_pkg::OP_MOVE) &&
                         (in_data_i.op != szp_pkg::OP_ADJUST) &&
                         (in_data_i.op != szp_pkg::OP_SENSE);
  assign sense_beat_ok = out_data_o.stepped || (out_data_o.last && (out_data_o.coils == 4'd0));

  `include "stepper_zone_positioner_assert.svh"

  `SZP_ASSERT(a_step_has_work, (state_q == szp_pkg::ST_STEP) |-> (left_q != '0), "empty step")
  `SZP_ASSERT(a_zone_range, (zone_q != 3'd0) && (zone_q <= 3'(szp_pkg::ZONES)), "bad zone")
  `SZP_ASSERT(a_sense_beat, out_valid_o |-> sense_beat_ok, "sense beat malformed")
  `SZP_ASSERT(a_bad_op_idle, (in_acc && op_unused) |=> (state_q == szp_pkg::ST_IDLE), "unused op ran")
  `SZP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> (!out_valid_o && !in_stall_o), "active in reset")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for the stepper zone positioner: directed and random move, adjust and sense
// commands with random idling on both sides, every output beat checked against a prediction
// depends on szp_pkg and stepper_zone_positioner

module tb_top;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 26;
  localparam int MAX_REPORTS   = 50;

  class coil_scoreboard;
    szp_pkg::out_beat_t expected_beats[$];
    int         errors;
    logic [3:0] coil_table[8];
    logic [2:0] zone;
    logic [2:0] phase;
    bit         fwd;
    logic [19:0] last_mm;
    bit         ok_flag;
    logic [4:0] spz;
    logic [3:0] adj;

    function new();
      coil_table = '{4'd5, 4'd1, 4'd9, 4'd8, 4'd10, 4'd2, 4'd6, 4'd4};
      errors  = 0;
      zone    = 3'd1;
      phase   = 3'd0;
      fwd     = 1'b1;
      last_mm = '0;
      ok_flag = 1'b0;
      spz     = 5'd16;
      adj     = 4'd3;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] val);
      if (idx == szp_pkg::CFG_ZONE_STEPS) spz = val;
      else if (idx == szp_pkg::CFG_TRIM_STEPS) adj = val[3:0];
    endfunction

    function void push_steps(int n);
      szp_pkg::out_beat_t b;
      for (int k = 0; k < n; k++) begin
        phase       = fwd ? phase + 3'd1 : phase - 3'd1;
        b.coils     = coil_table[phase];
        b.stepped   = 1'b1;
        b.near_ok   = ok_flag;
        b.last      = (k == n - 1);
        expected_beats.push_back(b);
      end
    endfunction

    function void note_command(szp_pkg::in_beat_t c);
      int d;
      int mm;
      int diff;
      szp_pkg::out_beat_t b;
      case (c.op)
        szp_pkg::OP_MOVE: begin
          if (c.target_zone >= 1 && c.target_zone <= szp_pkg::ZONES) begin
            d   = (int'(c.target_zone) + int'(szp_pkg::ZONES) - int'(zone)) %
                  int'(szp_pkg::ZONES);
            fwd = 1'b1;
            if (d > 3) begin
              d   = int'(szp_pkg::ZONES) - d;
              fwd = 1'b0;
            end
            zone = c.target_zone;
            push_steps(d * ((spz > szp_pkg::SPZ_MAX) ? int'(szp_pkg::SPZ_MAX) : int'(spz)));
          end
        end
        szp_pkg::OP_ADJUST: push_steps(int'(adj));
        szp_pkg::OP_SENSE: begin
          mm      = int'(c.sonar_count) * int'(szp_pkg::DIST_MUL) / int'(szp_pkg::DIST_DIV);
          diff    = int'(last_mm) - mm;
          last_mm = 20'(mm);
          if (diff > 0) fwd = ~fwd;
          ok_flag     = (diff >= 0 && diff < int'(szp_pkg::OK_LIMIT));
          b           = '0;
          b.near_ok   = ok_flag;
          b.last      = 1'b1;
          expected_beats.push_back(b);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_beat(szp_pkg::out_beat_t got);
      szp_pkg::out_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: beat expected none actual coils=%0d stepped=%0d ok=%0d last=%0d",
                   $time, got.coils, got.stepped, got.near_ok, got.last);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("coils", want.coils, got.coils);
      compare_field("stepped", want.stepped, got.stepped);
      compare_field("near_ok", want.near_ok, got.near_ok);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b1;
  logic       in_valid = 1'b0;
  szp_pkg::in_beat_t  in_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  szp_pkg::out_beat_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic       hold_req = 1'b0;

  coil_scoreboard sb;
  int tx_pct = 25;
  int rx_pct = 60;
  int gap_next = 0;
  bit in_held = 1'b0;
  bit cfg_held = 1'b0;
  int last_sonar = 0;

  stepper_zone_positioner dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin : rx_driver
    bit held_once;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_command(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_gap();
    int g;
    g = 0;
    while (g < 20 && $urandom_range(99) < tx_pct) g++;
    return g;
  endfunction

  function automatic szp_pkg::in_beat_t cmd(logic [1:0] op, logic [2:0] zone,
                                            logic [15:0] count);
    szp_pkg::in_beat_t c;
    c.op          = op;
    c.target_zone = zone;
    c.sonar_count = count;
    return c;
  endfunction

  function automatic szp_pkg::in_beat_t rand_cmd();
    int r;
    int c;
    szp_pkg::in_beat_t b;
    r = $urandom_range(99);
    b = cmd(OP_UNUSED, 3'($urandom), 16'($urandom));
    if (r < 4) return b;
    if (r < 50) begin
      b.op = szp_pkg::OP_MOVE;
      if ($urandom_range(99) < 6)
        b.target_zone = $urandom_range(1) ? 3'd7 : 3'd0;
      else
        b.target_zone = 3'($urandom_range(szp_pkg::ZONES, 1));
    end else if (r < 72) begin
      b.op = szp_pkg::OP_ADJUST;
    end else begin
      b.op = szp_pkg::OP_SENSE;
      // half the time a small change so that near and far moves of the target both show up
      if ($urandom_range(1)) begin
        c = last_sonar + int'($urandom_range(10)) - 5;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        b.sonar_count = 16'(c);
      end
      last_sonar = int'(b.sonar_count);
    end
    return b;
  endfunction

  task automatic send_cmd(input szp_pkg::in_beat_t b, input bit keep);
    repeat (gap_next) @(posedge clk);
    if (!in_held) in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap_next = keep ? idle_gap() : 0;
    in_held  = keep && (gap_next == 0);
    if (!in_held) in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val, input bit keep);
    if (!cfg_held) cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    if (!keep) cfg_valid <= 1'b0;
    cfg_held = keep;
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    szp_pkg::in_beat_t plan[$];
    szp_pkg::in_beat_t b;
    int         counted;
    logic [4:0] spz_val;
    logic [4:0] adj_val;

    sb = new();
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    plan = '{
      cmd(szp_pkg::OP_MOVE, 3'd1, 16'h0000),
      cmd(szp_pkg::OP_MOVE, 3'd4, 16'hFFFF),
      cmd(szp_pkg::OP_MOVE, 3'd3, 16'h0000),
      cmd(szp_pkg::OP_MOVE, 3'd0, 16'h1234),
      cmd(szp_pkg::OP_MOVE, 3'd7, 16'h0000),
      cmd(OP_UNUSED, 3'd7, 16'hFFFF),
      cmd(szp_pkg::OP_ADJUST, 3'd0, 16'h0000),
      cmd(szp_pkg::OP_SENSE, 3'd0, 16'h0000),
      cmd(szp_pkg::OP_SENSE, 3'd7, 16'hFFFF),
      cmd(szp_pkg::OP_SENSE, 3'd0, 16'hFFFA),
      cmd(szp_pkg::OP_SENSE, 3'd0, 16'hFFF6),
      cmd(szp_pkg::OP_SENSE, 3'd0, 16'hFFF6),
      cmd(szp_pkg::OP_ADJUST, 3'd5, 16'hAAAA),
      cmd(szp_pkg::OP_MOVE, 3'd6, 16'h5555),
      cmd(szp_pkg::OP_MOVE, 3'd2, 16'h0000),
      cmd(szp_pkg::OP_MOVE, 3'd1, 16'h0000),
      cmd(szp_pkg::OP_MOVE, 3'd5, 16'h0000),
      cmd(szp_pkg::OP_SENSE, 3'd0, 16'h5555),
      cmd(szp_pkg::OP_SENSE, 3'd0, 16'hAAAA)
    };
    foreach (plan[i]) send_cmd(plan[i], i != plan.size() - 1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p / 2)
        0: begin
          tx_pct = 25;
          rx_pct = 60;
        end
        1: begin
          tx_pct = 60;
          rx_pct = 25;
        end
        default: begin
          tx_pct = 0;
          rx_pct = 0;
        end
      endcase
      case (p)
        0: begin
          spz_val = 5'd1;
          adj_val = 5'd15;
        end
        1: begin
          spz_val = 5'd0;
          adj_val = 5'd0;
        end
        2: begin
          spz_val = 5'd31;
          adj_val = 5'h1F;
        end
        3: begin
          spz_val = 5'd2;
          adj_val = 5'd5;
        end
        4: begin
          spz_val = 5'd17;
          adj_val = 5'd0;
        end
        default: begin
          spz_val = 5'($urandom_range(szp_pkg::SPZ_MAX, 1));
          adj_val = 5'($urandom);
        end
      endcase
      write_reg(szp_pkg::CFG_ZONE_STEPS, spz_val, 1'b1);
      if (p == 2) begin
        write_reg(szp_pkg::CFG_TRIM_STEPS, adj_val, 1'b1);
        write_reg(CFG_UNUSED, 5'h1F, 1'b0);
      end else begin
        write_reg(szp_pkg::CFG_TRIM_STEPS, adj_val, 1'b0);
      end

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        b = rand_cmd();
        if (b.op != OP_UNUSED &&
            !(b.op == szp_pkg::OP_MOVE && (b.target_zone == 3'd0 || b.target_zone == 3'd7))) begin
          counted++;
          // long output hold-off so the block backs up into its input
          if (p == 0 && counted == 10) hold_req <= 1'b1;
        end
        send_cmd(b, counted < PHASE_ITEMS);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/szp_pkg.sv
hdl/stepper_zone_positioner.sv
verif/tb_top.sv
